// File: rtl/bbla_pkg.sv
// Package for the battery bar LED animator: payload structs, job record and constants.
// Used by every module of the block; depends on nothing.

package bbla_pkg;

    typedef struct packed {
        logic [6:0]  battery_percent;
        logic [1:0]  charger_state;
        logic [15:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [5:0] led_addr;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_led;
    } t_out_item;

    typedef enum logic [1:0] {
        BAND_RED,
        BAND_YELLOW,
        BAND_BLUE,
        BAND_GREEN
    } t_band;

    // One classified refresh, handed from the front end to the LED sequencer.
    typedef struct packed {
        t_band      band;
        logic       lit_all;
        logic [3:0] lit;
        logic       animate;
        logic [6:0] phase;
    } t_job;

    localparam logic [1:0] CHG_DISCHARGING = 2'd0;
    localparam logic [1:0] CHG_CHARGING    = 2'd1;
    localparam logic [1:0] CHG_FULL        = 2'd2;

    localparam logic [6:0]  PCT_MAX        = 7'd100;
    localparam logic [6:0]  PCT_RED_MAX    = 7'd10;
    localparam logic [6:0]  PCT_YELLOW_LIM = 7'd50;
    localparam logic [6:0]  PCT_BLUE_LIM   = 7'd80;
    localparam logic [6:0]  PCT_ROUND      = 7'd9;
    // Division by ten as a multiply by 205 and a shift by 11, exact up to 109.
    localparam logic [7:0]  DIV10_MUL      = 8'd205;
    localparam int          DIV10_SHIFT    = 11;

    localparam logic [15:0] STEP_MS_SHORT  = 16'd4;
    localparam logic [15:0] STEP_MS_LONG   = 16'd8;
    localparam logic [6:0]  PHASE_STEP     = 7'd3;
    localparam logic [6:0]  PHASE_WRAP     = 7'd127;
    localparam logic [6:0]  WAVE_ADVANCE   = 7'd8;
    localparam logic [7:0]  WAVE_FOLD      = 8'd128;
    localparam logic [7:0]  BRIGHT         = 8'd180;

    localparam int QUEUE_DEPTH = 2;

    // Which channels are lit in a band: {red, green, blue}.
    function automatic logic [2:0] band_mask(input t_band band);
        logic [2:0] m;
        case (band)
            BAND_RED:    m = 3'b100;
            BAND_YELLOW: m = 3'b110;
            BAND_BLUE:   m = 3'b001;
            BAND_GREEN:  m = 3'b010;
            default:     m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/bbla_front.sv
// Front end of the battery bar LED animator: accepts refresh items, steps the wave
// phase and classifies the item into a job. Depends on bbla_pkg.

module bbla_front
    import bbla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_backlight_off,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_job     o_job
);

    logic [6:0]  r_phase, n_phase;
    logic [15:0] r_last_step, n_last_step;

    logic        charging;
    logic        full;
    logic [6:0]  pct;
    logic [15:0] elapsed;
    logic [15:0] interval;
    logic [6:0]  pct_round;
    logic [14:0] lit_prod;
    t_band       band;

    always_comb begin
        charging  = (i_item.charger_state == CHG_CHARGING);
        full      = (i_item.charger_state == CHG_FULL);
        pct       = (i_item.battery_percent > PCT_MAX) ? PCT_MAX : i_item.battery_percent;
        interval  = i_backlight_off ? STEP_MS_LONG : STEP_MS_SHORT;
        elapsed   = i_item.now_ms - r_last_step;

        n_phase     = r_phase;
        n_last_step = r_last_step;
        if (charging) begin
            if (elapsed >= interval) begin
                n_last_step = i_item.now_ms;
                n_phase     = (r_phase > PHASE_STEP) ? r_phase - PHASE_STEP : PHASE_WRAP;
            end
        end else begin
            n_last_step = '0;
        end

        if (full) begin
            band = BAND_GREEN;
        end else if (pct <= PCT_RED_MAX) begin
            band = BAND_RED;
        end else if (pct < PCT_YELLOW_LIM) begin
            band = BAND_YELLOW;
        end else if (pct < PCT_BLUE_LIM) begin
            band = BAND_BLUE;
        end else begin
            band = BAND_GREEN;
        end

        pct_round = pct + PCT_ROUND;
        lit_prod  = 15'(pct_round) * 15'(DIV10_MUL);

        o_job.band    = band;
        o_job.lit_all = full;
        o_job.lit     = lit_prod[DIV10_SHIFT +: 4];
        o_job.animate = charging;
        // The step is taken before the colors of this refresh are formed.
        o_job.phase   = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_last_step <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_last_step <= n_last_step;
        end
    end

endmodule

// File: rtl/bbla_queue.sv
// Two-entry job queue between the front end and the LED sequencer.
// Depends on bbla_pkg for the job record and the depth.

module bbla_queue
    import bbla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/bbla_back.sv
// LED sequencer of the battery bar LED animator: walks the bar one LED per unstalled cycle,
// applies the triangle wave and holds each result in the output register. Depends on bbla_pkg.

module bbla_back
    import bbla_pkg::*;
#(
    parameter int BAR_LENGTH = 10,
    parameter int FIRST_LED  = 35
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int         IW       = (BAR_LENGTH > 1) ? $clog2(BAR_LENGTH) : 1;
    localparam int         CW       = (IW > 4) ? IW : 4;
    localparam logic [5:0] BASE_IDX = 6'(FIRST_LED);

    logic [IW-1:0] r_idx;
    logic [6:0]    r_pos;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          advance;
    logic          last;
    logic          lit;
    logic [6:0]    pos;
    logic [7:0]    fold;
    logic [9:0]    wave_raw;
    logic [7:0]    wave;
    logic [15:0]   scaled;
    logic [7:0]    level;
    logic [2:0]    mask;
    t_out_item     n_out;

    always_comb begin
        advance  = i_job_valid && (!r_out_valid || !i_out_stall);
        last     = (r_idx == IW'(BAR_LENGTH - 1));
        lit      = i_job.lit_all || (CW'(r_idx) < CW'(i_job.lit));
        pos      = (r_idx == '0) ? i_job.phase : r_pos;

        // Triangle wave: fold the upper half back, scale by four, clip at 255.
        fold     = pos[6] ? WAVE_FOLD - {1'b0, pos} : {1'b0, pos};
        wave_raw = {fold, 2'b00};
        wave     = (wave_raw > 10'd255) ? 8'hFF : wave_raw[7:0];
        scaled   = 16'(BRIGHT) * 16'(wave);

        level    = i_job.animate ? scaled[15:8] : BRIGHT;
        mask     = lit ? band_mask(i_job.band) : 3'b000;

        n_out.led_addr  = BASE_IDX + 6'(r_idx);
        n_out.red       = mask[2] ? level : 8'd0;
        n_out.green     = mask[1] ? level : 8'd0;
        n_out.blue      = mask[0] ? level : 8'd0;
        n_out.last_led  = last;

        o_job_pop = advance && last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
            // The wave position moves on only past a lit LED.
            r_pos <= (lit && i_job.animate) ? pos + WAVE_ADVANCE : pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx       <= last ? '0 : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/battery_bar_led_animator_core.sv
// Battery bar LED animator, top level. A refresh item is taken when the two-entry job
// queue has room; its job is written into the queue, and the LED sequencer registers its
// first LED result, followed by the rest of the bar at one LED per cycle while the output
// is not stalled. The sequencer starts a new job only after the last LED of the previous one.
// Synchronous active-low reset clears the wave phase, the step timer, the register,
// the queue and the output valid.

module battery_bar_led_animator_core
    import bbla_pkg::*;
#(
    parameter int BAR_LENGTH = 10,
    parameter int FIRST_LED  = 35
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    logic r_backlight_off;
    logic in_accept;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job front_job;
    t_job q_job;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight_off <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_backlight_off <= i_cfg_data;
        end
    end

    bbla_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_backlight_off (r_backlight_off),
        .i_accept        (in_accept),
        .i_item          (i_in_data),
        .o_job           (front_job)
    );

    bbla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    bbla_back #(
        .BAR_LENGTH (BAR_LENGTH),
        .FIRST_LED  (FIRST_LED)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/bbla_checker.sv
// Port-level checker for the battery bar LED animator, bound to the top level.
// Depends on bbla_pkg for the payload structs.

module bbla_checker
    import bbla_pkg::*;
#(
    parameter int BAR_LENGTH = 10,
    parameter int FIRST_LED  = 35
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data,
    input logic      i_cfg_valid,
    input logic      o_cfg_ready,
    input logic      i_cfg_data
);

    localparam logic [5:0] FIRST_IDX = 6'(FIRST_LED);
    localparam logic [5:0] LAST_IDX  = 6'(FIRST_LED + BAR_LENGTH - 1);

    logic [5:0] r_exp_idx;

    // Expected LED index of the next result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= FIRST_IDX;
        end else if (o_out_valid && !i_out_stall) begin
            r_exp_idx <= o_out_data.last_led ? FIRST_IDX : r_exp_idx + 6'd1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.led_addr == r_exp_idx)
        else $error("LED results out of order");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.last_led == (o_out_data.led_addr == LAST_IDX))
        else $error("last_led does not mark the final LED");

    a_band_colors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.red != 8'd0 && o_out_data.blue != 8'd0))
        else $error("red and blue lit together");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind battery_bar_led_animator_core bbla_checker #(
    .BAR_LENGTH (BAR_LENGTH),
    .FIRST_LED  (FIRST_LED)
) u_bbla_checker (.*);
